// File: sv/hus_pkg.sv
`default_nettype none

package hus_pkg;

    // feature vector and per-entry widths
    localparam int FEAT_W    = 64;
    localparam int W_W       = 7;
    localparam int LANES     = 8;
    localparam int LANE_BITS = 3;
    localparam int CONTRIB_W = 7;
    localparam int LSUM_W    = CONTRIB_W + LANE_BITS;
    localparam int Q_W       = 17;
    localparam int FRAC_BITS = 16;
    localparam int OUT_W     = 17;
    localparam logic [OUT_W-1:0] FIELD17_MAX = 17'h1FFFF;

    // command codes, code 3 means nothing
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MULT,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    // one stored reference entry
    typedef struct packed {
        logic              cls;
        logic [FEAT_W-1:0] feat;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic add;
    } merge_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // width in use: zero counts as one, above the vector width saturates
    function automatic logic [W_W-1:0] clamp_width(input logic [W_W-1:0] v);
        logic [W_W-1:0] w;
        w = v;
        if (v == '0)
        begin
            w = W_W'(1);
        end
        else if (v > W_W'(FEAT_W))
        begin
            w = W_W'(FEAT_W);
        end
        return w;
    endfunction

    // mask of the low w feature bits
    function automatic logic [FEAT_W-1:0] width_mask(input logic [W_W-1:0] w);
        logic [FEAT_W-1:0] m;
        if (w >= W_W'(FEAT_W))
        begin
            m = '1;
        end
        else
        begin
            m = (FEAT_W'(1) << w) - FEAT_W'(1);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: sv/hus_lane.sv
`default_nettype none

module hus_lane (
    input  wire logic                                clk,
    input  wire hus_pkg::entry_t                     entry,
    input  wire logic                                entry_vld,
    input  wire logic [hus_pkg::FEAT_W-1:0]          query_feat,
    input  wire logic                                query_cls,
    input  wire logic [hus_pkg::FEAT_W-1:0]          mask,
    input  wire logic [hus_pkg::W_W-1:0]             width,
    output logic      [hus_pkg::CONTRIB_W-1:0]       contrib
);

    logic [hus_pkg::CONTRIB_W-1:0] diff;
    logic [hus_pkg::CONTRIB_W-1:0] contrib_next;
    logic [hus_pkg::CONTRIB_W-1:0] contrib_reg;

    // differing features on the active bits
    assign diff = hus_pkg::CONTRIB_W'($countones((query_feat ^ entry.feat) & mask));

    // same class scores agreement, other class scores disagreement
    always_comb
    begin
        contrib_next = '0;
        if (entry_vld)
        begin
            if (entry.cls == query_cls)
            begin
                contrib_next = hus_pkg::CONTRIB_W'(width) - diff;
            end
            else
            begin
                contrib_next = diff;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        contrib_reg <= contrib_next;
    end

    assign contrib = contrib_reg;

endmodule

`default_nettype wire

// File: sv/hus_merge.sv
`default_nettype none

module hus_merge #(
    parameter int SUM_W = 17
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire hus_pkg::merge_ctl_t               ctl,
    input  wire logic [hus_pkg::CONTRIB_W-1:0]     contrib [hus_pkg::LANES],
    output logic      [SUM_W-1:0]                  sum
);

    logic [hus_pkg::LSUM_W-1:0] row_sum;
    logic [SUM_W-1:0]           sum_next;
    logic [SUM_W-1:0]           sum_reg;

    // add up the lanes of one row
    always_comb
    begin
        row_sum = '0;
        for (int l = 0; l < hus_pkg::LANES; l++)
        begin
            row_sum = row_sum + hus_pkg::LSUM_W'(contrib[l]);
        end
    end

    // running total over the scanned rows
    always_comb
    begin
        sum_next = sum_reg;
        if (ctl.clear)
        begin
            sum_next = '0;
        end
        else if (ctl.add)
        begin
            sum_next = sum_reg + SUM_W'(row_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

// File: sv/hus_divider.sv
`default_nettype none

module hus_divider #(
    parameter int D_W = 17
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [D_W-1:0]              num,
    input  wire logic [D_W-1:0]              den,
    output hus_pkg::div_stat_t               stat,
    output logic      [hus_pkg::Q_W-1:0]     quo
);

    // num <= den, so the quotient of num*2^16/den fits in Q_W bits
    localparam int STEP_W = $clog2(hus_pkg::Q_W + 1);

    logic [D_W-1:0]             rem_reg;
    logic [D_W-1:0]             rem_next;
    logic [D_W-1:0]             den_reg;
    logic [D_W-1:0]             den_next;
    logic [hus_pkg::Q_W-1:0]    quo_reg;
    logic [hus_pkg::Q_W-1:0]    quo_next;
    logic [STEP_W-1:0]          step_reg;
    logic [STEP_W-1:0]          step_next;
    logic                       busy_reg;
    logic                       busy_next;
    logic                       done_reg;
    logic                       done_next;
    logic [D_W:0]               trial;
    logic                       fits;

    // first step takes the integer bit, later ones shift in a zero
    assign trial = (step_reg == STEP_W'(hus_pkg::Q_W)) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign fits  = (trial >= {1'b0, den_reg});

    // one restoring step per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            quo_next  = '0;
            step_next = STEP_W'(hus_pkg::Q_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = D_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_next = D_W'(trial);
            end
            quo_next  = {quo_reg[hus_pkg::Q_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

`default_nettype wire

// File: sv/hamming_uniqueness_scorer.sv
// channel  handshake             word
// -------  --------------------  ------------------------------------------------
// in       in_valid / in_stall   command, features, class_bit
// out      out_valid / out_stall status, agreement_sum, uniqueness_q16
// cfg      cfg_we                cfg_wdata (active_features)
//
// clear, load and the unused code go from accept straight to the done state.
// a query reads one memory row of 8 entries per cycle into 8 compare lanes, then
// drains the lanes, forms N*W and runs the bit-serial divider.
// reset empties the set and sets active_features to 64; the memory is not swept.
// a stalled result sits in the output register while the next word is accepted.
`default_nettype none

module hamming_uniqueness_scorer #(
    parameter int MAX_REFS = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         command,
    input  wire logic [hus_pkg::FEAT_W-1:0]         features,
    input  wire logic                               class_bit,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [1:0]                         status,
    output logic      [hus_pkg::OUT_W-1:0]          agreement_sum,
    output logic      [hus_pkg::OUT_W-1:0]          uniqueness_q16,
    input  wire logic                               cfg_we,
    input  wire logic [hus_pkg::W_W-1:0]            cfg_wdata
);

    localparam int LANES   = hus_pkg::LANES;
    localparam int LB      = hus_pkg::LANE_BITS;
    localparam int ROWS    = (MAX_REFS + LANES - 1) / LANES;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_RAW = $clog2(MAX_REFS + 1);
    localparam int CNT_W   = (CNT_RAW > LB + 1) ? CNT_RAW : LB + 1;
    localparam int IDX_W   = ROW_W + LB;
    localparam int CMP_W   = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam int SUM_W   = $clog2(MAX_REFS * hus_pkg::FEAT_W + 1);
    localparam int SATW    = SUM_W + hus_pkg::OUT_W;

    hus_pkg::state_t state_reg;
    hus_pkg::state_t state_next;

    logic                         accept;
    logic                         issue;
    logic                         div_start;
    logic                         out_load;
    hus_pkg::merge_ctl_t          merge_ctl;
    hus_pkg::div_stat_t           div_stat;

    logic [CNT_W-1:0]             count_reg;
    logic [hus_pkg::W_W-1:0]      active_features_reg;
    logic [ROW_W-1:0]             scan_row_reg;
    logic                         rd_vld_reg;
    logic                         lane_vld_reg;
    logic                         out_valid_reg;
    logic                         full;
    logic                         empty;

    logic [hus_pkg::FEAT_W-1:0]   qfeat_reg;
    logic                         qcls_reg;
    logic [hus_pkg::FEAT_W-1:0]   mask_reg;
    logic [hus_pkg::W_W-1:0]      w_reg;
    logic [ROW_W-1:0]             last_row_reg;
    logic [ROW_W-1:0]             rd_row_idx_reg;
    logic [SUM_W-1:0]             total_reg;

    hus_pkg::status_t             res_status_reg;
    logic [hus_pkg::OUT_W-1:0]    res_sum_reg;
    logic [hus_pkg::OUT_W-1:0]    res_uniq_reg;
    hus_pkg::status_t             out_status_reg;
    logic [hus_pkg::OUT_W-1:0]    out_sum_reg;
    logic [hus_pkg::OUT_W-1:0]    out_uniq_reg;

    hus_pkg::entry_t              ref_mem_reg [ROWS][LANES];
    hus_pkg::entry_t              rd_row_data_reg [LANES];
    hus_pkg::entry_t              wr_entry;
    logic [ROW_W-1:0]             wr_row;
    logic [LB-1:0]                wr_lane;

    logic [LANES-1:0]             lane_en;
    logic [hus_pkg::CONTRIB_W-1:0] contrib [LANES];
    logic [SUM_W-1:0]             sum;
    logic [hus_pkg::Q_W-1:0]      quo;
    logic [SATW-1:0]              sum_wide;
    logic [hus_pkg::OUT_W-1:0]    sum_sat;

    assign full   = (count_reg >= CNT_W'(MAX_REFS));
    assign empty  = (count_reg == '0);
    assign accept = in_valid && !in_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hus_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if ((hus_pkg::cmd_t'(command) == hus_pkg::CMD_QUERY) && !empty)
                    begin
                        state_next = hus_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = hus_pkg::ST_DONE;
                    end
                end
            end
            hus_pkg::ST_SCAN:
            begin
                if (scan_row_reg == last_row_reg)
                begin
                    state_next = hus_pkg::ST_DRAIN;
                end
            end
            hus_pkg::ST_DRAIN:
            begin
                if (!rd_vld_reg && !lane_vld_reg)
                begin
                    state_next = hus_pkg::ST_MULT;
                end
            end
            hus_pkg::ST_MULT:
            begin
                state_next = hus_pkg::ST_DIV_LOAD;
            end
            hus_pkg::ST_DIV_LOAD:
            begin
                state_next = hus_pkg::ST_DIV_WAIT;
            end
            hus_pkg::ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = hus_pkg::ST_DONE;
                end
            end
            hus_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = hus_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hus_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall  = 1'b1;
        issue     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            hus_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            hus_pkg::ST_SCAN:
            begin
                issue = 1'b1;
            end
            hus_pkg::ST_DIV_LOAD:
            begin
                div_start = 1'b1;
            end
            hus_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        merge_ctl.clear = accept && (hus_pkg::cmd_t'(command) == hus_pkg::CMD_QUERY);
        merge_ctl.add   = lane_vld_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= hus_pkg::ST_IDLE;
            count_reg           <= '0;
            active_features_reg <= hus_pkg::W_W'(hus_pkg::FEAT_W);
            scan_row_reg        <= '0;
            rd_vld_reg          <= 1'b0;
            lane_vld_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_vld_reg   <= issue;
            lane_vld_reg <= rd_vld_reg;
            if (cfg_we)
            begin
                active_features_reg <= cfg_wdata;
            end
            if (accept)
            begin
                scan_row_reg <= '0;
                case (hus_pkg::cmd_t'(command))
                    hus_pkg::CMD_CLEAR:
                    begin
                        count_reg <= '0;
                    end
                    hus_pkg::CMD_LOAD:
                    begin
                        if (!full)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        count_reg <= count_reg;
                    end
                endcase
            end
            else if (issue)
            begin
                scan_row_reg <= scan_row_reg + ROW_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // query operands, latched at accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qfeat_reg    <= features;
            qcls_reg     <= class_bit;
            w_reg        <= hus_pkg::clamp_width(active_features_reg);
            mask_reg     <= hus_pkg::width_mask(hus_pkg::clamp_width(active_features_reg));
            last_row_reg <= ROW_W'((count_reg - CNT_W'(1)) >> LB);
        end
    end

    // reference memory: one entry written, one row of lanes read
    assign wr_row        = ROW_W'(count_reg >> LB);
    assign wr_lane       = count_reg[LB-1:0];
    assign wr_entry.cls  = class_bit;
    assign wr_entry.feat = features;

    always_ff @(posedge clk)
    begin
        if (accept && (hus_pkg::cmd_t'(command) == hus_pkg::CMD_LOAD) && !full)
        begin
            ref_mem_reg[wr_row][wr_lane] <= wr_entry;
        end
        if (issue)
        begin
            rd_row_data_reg <= ref_mem_reg[scan_row_reg];
            rd_row_idx_reg  <= scan_row_reg;
        end
    end

    // lanes past the fill count contribute nothing
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_en[l] = CMP_W'({rd_row_idx_reg, LB'(l)}) < CMP_W'(count_reg);
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        hus_lane u_lane (
            .clk        (clk),
            .entry      (rd_row_data_reg[l]),
            .entry_vld  (lane_en[l]),
            .query_feat (qfeat_reg),
            .query_cls  (qcls_reg),
            .mask       (mask_reg),
            .width      (w_reg),
            .contrib    (contrib[l])
        );
    end

    hus_merge #(
        .SUM_W (SUM_W)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (merge_ctl),
        .contrib (contrib),
        .sum     (sum)
    );

    // N*W for the score denominator
    always_ff @(posedge clk)
    begin
        if (state_reg == hus_pkg::ST_MULT)
        begin
            total_reg <= SUM_W'(count_reg) * SUM_W'(w_reg);
        end
    end

    hus_divider #(
        .D_W (SUM_W)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (total_reg - sum),
        .den   (total_reg),
        .stat  (div_stat),
        .quo   (quo)
    );

    // saturate the sum into its field
    assign sum_wide = SATW'(sum);
    assign sum_sat  = (sum_wide > SATW'(hus_pkg::FIELD17_MAX)) ? hus_pkg::FIELD17_MAX
                                                                : sum_wide[hus_pkg::OUT_W-1:0];

    // pending result, then output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_sum_reg  <= '0;
            res_uniq_reg <= '0;
            if ((hus_pkg::cmd_t'(command) == hus_pkg::CMD_LOAD) && full)
            begin
                res_status_reg <= hus_pkg::STAT_FULL;
            end
            else if ((hus_pkg::cmd_t'(command) == hus_pkg::CMD_QUERY) && empty)
            begin
                res_status_reg <= hus_pkg::STAT_EMPTY;
            end
            else
            begin
                res_status_reg <= hus_pkg::STAT_OK;
            end
        end
        else if ((state_reg == hus_pkg::ST_DIV_WAIT) && div_stat.done)
        begin
            res_status_reg <= hus_pkg::STAT_OK;
            res_sum_reg    <= sum_sat;
            res_uniq_reg   <= quo;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_sum_reg    <= res_sum_reg;
            out_uniq_reg   <= res_uniq_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign agreement_sum  = out_sum_reg;
    assign uniqueness_q16 = out_uniq_reg;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_REFS))
        else $error("fill count beyond set size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hus_pkg::ST_MULT) |-> (!rd_vld_reg && !lane_vld_reg))
        else $error("lane pipeline not empty at multiply");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hus_pkg::ST_DIV_LOAD) |-> (sum <= total_reg))
        else $error("agreement sum above N*W");

    assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat.busy || div_stat.done) |-> (state_reg == hus_pkg::ST_DIV_WAIT))
        else $error("divider running outside its wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != hus_pkg::STAT_OK))
            |-> (out_sum_reg == '0 && out_uniq_reg == '0))
        else $error("error result carries nonzero fields");

endmodule

`default_nettype wire

// File: test/tb.sv
`default_nettype none

module tb;

    localparam int SET_DEPTH = 1024;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // slowest quiet stretch: the receiver hold-off plus a full-set query
    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 160;

    // one expected result word
    typedef struct packed {
        hus_pkg::status_t            status;
        logic [hus_pkg::OUT_W-1:0]   sum;
        logic [hus_pkg::OUT_W-1:0]   uniq;
    } score_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [1:0]                      command = 2'd0;
    logic [hus_pkg::FEAT_W-1:0]      features = '0;
    logic                            class_bit = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [1:0]                      status;
    logic [hus_pkg::OUT_W-1:0]       agreement_sum;
    logic [hus_pkg::OUT_W-1:0]       uniqueness_q16;
    logic                            cfg_we = 1'b0;
    logic [hus_pkg::W_W-1:0]         cfg_wdata = '0;

    // predictor copy of the reference set and the width register
    logic [hus_pkg::FEAT_W-1:0]      set_feat [SET_DEPTH];
    logic                            set_cls [SET_DEPTH];
    int unsigned                     set_size = 0;
    logic [hus_pkg::W_W-1:0]         feat_width = 7'd64;

    score_t                 pending_scores [$];
    int                     mismatches = 0;
    int                     send_pct = 0;
    int                     recv_pct = 0;
    logic                   hold_req = 1'b0;
    logic                   hold_done = 1'b0;
    int                     hold_left = 0;

    hamming_uniqueness_scorer #(
        .MAX_REFS(SET_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .features(features),
        .class_bit(class_bit),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .agreement_sum(agreement_sum),
        .uniqueness_q16(uniqueness_q16),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #4 clk = ~clk;

    // expected score of one word, updates the predicted set
    function automatic score_t score_word(input logic [1:0] cmd,
                                          input logic [hus_pkg::FEAT_W-1:0] feat,
                                          input logic cls);
        score_t         r;
        int unsigned    w;
        int unsigned    diff;
        int unsigned    s;
        int unsigned    total;
        logic [63:0]    mask;
        logic [63:0]    q;
        r.status = hus_pkg::STAT_OK;
        r.sum = '0;
        r.uniq = '0;
        case (cmd)
            hus_pkg::CMD_CLEAR:
            begin
                set_size = 0;
            end
            hus_pkg::CMD_LOAD:
            begin
                if (set_size >= SET_DEPTH)
                begin
                    r.status = hus_pkg::STAT_FULL;
                end
                else
                begin
                    set_feat[set_size] = feat;
                    set_cls[set_size] = cls;
                    set_size++;
                end
            end
            hus_pkg::CMD_QUERY:
            begin
                if (set_size == 0)
                begin
                    r.status = hus_pkg::STAT_EMPTY;
                end
                else
                begin
                    w = feat_width;
                    if (w < 1)
                    begin
                        w = 1;
                    end
                    if (w > hus_pkg::FEAT_W)
                    begin
                        w = hus_pkg::FEAT_W;
                    end
                    if (w >= 64)
                    begin
                        mask = '1;
                    end
                    else
                    begin
                        mask = (64'd1 << w) - 64'd1;
                    end
                    s = 0;
                    for (int k = 0; k < set_size; k++)
                    begin
                        diff = $countones((feat ^ set_feat[k]) & mask);
                        s += (set_cls[k] == cls) ? (w - diff) : diff;
                    end
                    total = set_size * w;
                    q = ({32'd0, total - s} << 16) / {32'd0, total};
                    r.sum = (s > 131071) ? hus_pkg::FIELD17_MAX : s[hus_pkg::OUT_W-1:0];
                    r.uniq = q[hus_pkg::OUT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [hus_pkg::FEAT_W-1:0] rand_vec();
        logic [hus_pkg::FEAT_W-1:0] v;
        case ($urandom_range(7))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [hus_pkg::W_W-1:0] pick_width();
        logic [hus_pkg::W_W-1:0] w;
        case ($urandom_range(7))
            0: w = 7'd1;
            1: w = 7'd0;
            2: w = 7'd127;
            3: w = 7'd64;
            4: w = 7'd65;
            5: w = 7'd63;
            default: w = hus_pkg::W_W'($urandom_range(1, 64));
        endcase
        return w;
    endfunction

    // offer one word, record its expected score once accepted
    task automatic send_word(input logic [1:0] cmd, input logic [hus_pkg::FEAT_W-1:0] feat,
                             input logic cls);
        if ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_pct);
        end
        command <= cmd;
        features <= feat;
        class_bit <= cls;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_scores.insert(pending_scores.size(), score_word(cmd, feat, cls));
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_scores.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // width register write, only with the block idle
    task automatic set_width(input logic [hus_pkg::W_W-1:0] w);
        wait_drain();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        feat_width = w;
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int s, input int r);
        send_pct = s;
        recv_pct <= r;
    endtask

    task automatic test_directed();
        send_word(hus_pkg::CMD_QUERY, 64'h0123_4567_89AB_CDEF, 1'b0);
        send_word(CMD_UNUSED, '1, 1'b1);
        send_word(hus_pkg::CMD_LOAD, '0, 1'b0);
        send_word(hus_pkg::CMD_LOAD, '1, 1'b1);
        send_word(hus_pkg::CMD_LOAD, 64'h5555_5555_5555_5555, 1'b0);
        send_word(hus_pkg::CMD_QUERY, '1, 1'b1);
        send_word(hus_pkg::CMD_QUERY, '0, 1'b0);
        send_word(hus_pkg::CMD_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        send_word(hus_pkg::CMD_QUERY, '0, 1'b1);
        send_word(CMD_UNUSED, 64'hDEAD_BEEF_0BAD_F00D, 1'b0);
        send_word(hus_pkg::CMD_LOAD, '1, 1'b0);
        send_word(hus_pkg::CMD_QUERY, rand_vec(), 1'b1);
        send_word(hus_pkg::CMD_CLEAR, '1, 1'b1);
        send_word(hus_pkg::CMD_QUERY, '1, 1'b1);
        send_word(hus_pkg::CMD_LOAD, 64'h8000_0000_0000_0000, 1'b1);
        send_word(hus_pkg::CMD_QUERY, 64'h8000_0000_0000_0000, 1'b1);
        send_word(hus_pkg::CMD_QUERY, '0, 1'b1);
    endtask

    // width of one, zero, and beyond the vector width
    task automatic test_width_limits();
        send_word(hus_pkg::CMD_CLEAR, '0, 1'b0);
        send_word(hus_pkg::CMD_LOAD, 64'h8000_0000_0000_0001, 1'b1);
        set_width(7'd1);
        send_word(hus_pkg::CMD_QUERY, '0, 1'b1);
        set_width(7'd0);
        send_word(hus_pkg::CMD_QUERY, 64'd1, 1'b0);
        set_width(7'd127);
        send_word(hus_pkg::CMD_QUERY, '0, 1'b1);
        set_width(7'd65);
        send_word(hus_pkg::CMD_QUERY, '1, 1'b0);
        set_width(7'd64);
    endtask

    // clear (not always), load a set, then query it, with width changes and stray words mixed in
    task automatic test_traffic(input int n_words);
        int             sent;
        int             n_load;
        int             n_ask;
        int             idx;
        int             i;
        logic [63:0]    base;
        logic [63:0]    v;
        logic           c;
        sent = 0;
        while (sent < n_words)
        begin
            if ($urandom_range(3) == 0)
            begin
                set_width(pick_width());
            end
            if (set_size > 800 || $urandom_range(4) != 0)
            begin
                send_word(hus_pkg::CMD_CLEAR, rand_vec(), 1'($urandom_range(1)));
                sent++;
            end
            if (set_size == 0 && $urandom_range(5) == 0)
            begin
                send_word(hus_pkg::CMD_QUERY, rand_vec(), 1'($urandom_range(1)));
                sent++;
            end
            n_load = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
            base = rand_vec();
            for (i = 0; i < n_load; i++)
            begin
                v = ($urandom_range(1) == 0) ? rand_vec() : base ^ (64'd1 << $urandom_range(63));
                send_word(hus_pkg::CMD_LOAD, v, 1'($urandom_range(1)));
                sent++;
                if ($urandom_range(19) == 0)
                begin
                    send_word(CMD_UNUSED, rand_vec(), 1'($urandom_range(1)));
                    sent++;
                end
            end
            if (set_size <= 40 && $urandom_range(3) == 0)
            begin
                // self mode: query every stored entry
                for (i = 0; i < set_size; i++)
                begin
                    send_word(hus_pkg::CMD_QUERY, set_feat[i], set_cls[i]);
                    sent++;
                end
            end
            else
            begin
                n_ask = $urandom_range(1, 12);
                for (i = 0; i < n_ask; i++)
                begin
                    idx = $urandom_range(set_size - 1);
                    case ($urandom_range(3))
                        0:
                        begin
                            v = set_feat[idx];
                            c = set_cls[idx];
                        end
                        1:
                        begin
                            v = rand_vec();
                            c = 1'($urandom_range(1));
                        end
                        2:
                        begin
                            v = ~set_feat[idx];
                            c = ~set_cls[idx];
                        end
                        default:
                        begin
                            v = base;
                            c = 1'($urandom_range(1));
                        end
                    endcase
                    send_word(hus_pkg::CMD_QUERY, v, c);
                    sent++;
                end
            end
        end
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        int i;
        hold_req <= 1'b1;
        send_word(hus_pkg::CMD_CLEAR, '0, 1'b0);
        for (i = 0; i < 8; i++)
        begin
            send_word(hus_pkg::CMD_LOAD, rand_vec(), 1'($urandom_range(1)));
        end
        for (i = 0; i < 15; i++)
        begin
            send_word(hus_pkg::CMD_QUERY, rand_vec(), 1'($urandom_range(1)));
        end
        wait_drain();
    endtask

    // fill the set to capacity with one vector, overflow it, query the extremes
    task automatic test_full_set();
        logic [63:0]    v;
        logic           c;
        int             i;
        set_width(7'd64);
        v = {$urandom, $urandom};
        c = 1'($urandom_range(1));
        send_word(hus_pkg::CMD_CLEAR, '0, 1'b0);
        for (i = 0; i < SET_DEPTH; i++)
        begin
            send_word(hus_pkg::CMD_LOAD, v, c);
        end
        send_word(hus_pkg::CMD_LOAD, ~v, ~c);
        send_word(hus_pkg::CMD_LOAD, v, c);
        send_word(hus_pkg::CMD_QUERY, v, c);
        send_word(hus_pkg::CMD_QUERY, ~v, c);
        send_word(hus_pkg::CMD_QUERY, v, ~c);
        send_word(hus_pkg::CMD_QUERY, rand_vec(), 1'($urandom_range(1)));
        set_width(7'd1);
        send_word(hus_pkg::CMD_QUERY, v, c);
        send_word(hus_pkg::CMD_QUERY, ~v, c);
        send_word(hus_pkg::CMD_CLEAR, '1, 1'b1);
    endtask

    // receiver stall, with one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    // compare each accepted result word with the oldest expected score
    always @(posedge clk)
    begin : check_results
        score_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_scores.size() == 0)
            begin
                $error("result word with no expected score: status %0d sum %0d uniq %0d",
                       status, agreement_sum, uniqueness_q16);
                mismatches++;
            end
            else
            begin
                want = pending_scores.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
                if (agreement_sum !== want.sum)
                begin
                    $error("agreement_sum: expected %0d, got %0d", want.sum, agreement_sum);
                    mismatches++;
                end
                if (uniqueness_q16 !== want.uniq)
                begin
                    $error("uniqueness_q16: expected %0d, got %0d", want.uniq, uniqueness_q16);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // test sequence
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(7, 66);
        test_directed();
        test_width_limits();
        test_traffic(280);
        set_idling(66, 7);
        test_traffic(280);
        set_idling(0, 0);
        test_backpressure();
        test_full_set();
        test_traffic(280);
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_scores.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: hamming_uniqueness_scorer.f
sv/hus_pkg.sv
sv/hus_lane.sv
sv/hus_merge.sv
sv/hus_divider.sv
sv/hamming_uniqueness_scorer.sv
test/tb.sv
